>>> src/kws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared types and opcodes, and the letter decode used by the datapath.
// ----------------------------------------------------------------------------
package kws_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] UPPER_BASE = 8'd65;
    localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd97;

    typedef enum logic [1:0] {
        OP_KEY     = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_CLEAR   = 2'd3
    } kws_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_ENC
    } kws_state_t;

    typedef struct packed {
        logic do_key;
        logic do_clear;
        logic start_close;
        logic walk_step;
        logic enc_capture;
        logic enc_load;
    } kws_cmd_t;

    typedef struct packed {
        logic key_closed;
        logic walk_last;
        logic out_free;
    } kws_stat_t;

    typedef struct packed {
        logic                hit;
        logic [LETTER_W-1:0] idx;
    } kws_letter_t;

    // Letter position of an ASCII character of either case.
    function automatic kws_letter_t letter_lookup(input logic [CHAR_W-1:0] c);
        kws_letter_t         res;
        logic [CHAR_W-1:0]   off_u;
        logic [CHAR_W-1:0]   off_l;
        off_u   = c - UPPER_BASE;
        off_l   = c - LOWER_BASE;
        res.hit = 1'b0;
        res.idx = '0;
        if (c >= UPPER_BASE && off_u < CHAR_W'(NUM_LETTERS)) begin
            res.hit = 1'b1;
            res.idx = off_u[LETTER_W-1:0];
        end else if (c >= LOWER_BASE && off_l < CHAR_W'(NUM_LETTERS)) begin
            res.hit = 1'b1;
            res.idx = off_l[LETTER_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/keyword_substitution_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher
// Builds a substitution alphabet from key characters and enciphers messages.
//
//   Channel | Direction | Signals
//   s_      | in        | s_valid, s_ready, s_opcode[1:0], s_char_in[7:0]
//   m_      | out       | m_valid, m_ready, m_char_out[7:0], m_not_ready
//
// Key character and clear requests complete as they are taken. For an encrypt,
// the substitution table read is registered before the output register loads.
// Close of an open key walks over the 26 letters and uses the single table
// write port, one letter a cycle; a close of a key that is already closed
// completes as it is taken. Reset is synchronous and active low; the table itself
// is not cleared. A request is taken only while the output register is empty
// or being drained, so a stalled result holds the input.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
    import kws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic        m_not_ready
);

    kws_cmd_t  cmd;
    kws_stat_t stat;

    kws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kws_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_char_in   (s_char_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_not_ready (m_not_ready)
    );

    // The output register must be empty whenever a table read result lands.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enc_load |-> !m_valid)
        else $error("result loaded while output register still full");

    // An accepted encrypt request loads a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_ENCRYPT) |=> cmd.enc_load)
        else $error("encrypt request produced no result");

    // No request is taken during the close walk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> !s_ready)
        else $error("request accepted during close walk");

endmodule

>>> src/kws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher controller
// Request acceptance and sequencing of close walks and encrypt table reads.
// ----------------------------------------------------------------------------
module kws_ctrl
    import kws_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_opcode,
    output logic                s_ready,
    input  kws_stat_t           stat,
    output kws_cmd_t            cmd
);

    kws_state_t state_reg;
    kws_state_t state_next;
    kws_op_t    op;
    logic       take;

    assign op      = kws_op_t'(s_opcode);
    assign s_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign take    = s_ready && s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (op == OP_CLOSE && !stat.key_closed) begin
                        state_next = ST_CLOSE;
                    end else if (op == OP_ENCRYPT) begin
                        state_next = ST_ENC;
                    end
                end
            end
            ST_CLOSE: begin
                if (stat.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENC:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (op)
                        OP_KEY:     cmd.do_key      = 1'b1;
                        OP_CLOSE:   cmd.start_close = !stat.key_closed;
                        OP_ENCRYPT: cmd.enc_capture = 1'b1;
                        OP_CLEAR:   cmd.do_clear    = 1'b1;
                        default:    cmd.do_key      = 1'b0;
                    endcase
                end
            end
            ST_CLOSE: cmd.walk_step = 1'b1;
            ST_ENC:   cmd.enc_load  = 1'b1;
            default:  cmd.walk_step = 1'b0;
        endcase
    end

endmodule

>>> src/kws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher datapath
// Substitution table memory, key bookkeeping and the output register.
// ----------------------------------------------------------------------------
module kws_dp
    import kws_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  kws_cmd_t            cmd,
    output kws_stat_t           stat,
    input  logic [CHAR_W-1:0]   s_char_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_char_out,
    output logic                m_not_ready
);

    logic [LETTER_W-1:0]    table_mem [NUM_LETTERS];

    logic [NUM_LETTERS-1:0] used_reg,   used_next;
    logic [LETTER_W-1:0]    fill_reg,   fill_next;
    logic                   closed_reg, closed_next;
    logic [LETTER_W-1:0]    walk_reg,   walk_next;
    logic                   m_valid_reg, m_valid_next;

    logic [LETTER_W-1:0]    rd_data_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   not_ready_reg;
    logic                   subst_reg;
    logic [CHAR_W-1:0]      m_char_reg;
    logic                   m_not_ready_reg;

    kws_letter_t            lk;
    logic                   key_place;
    logic                   walk_place;
    logic                   place;
    logic [LETTER_W-1:0]    place_idx;
    logic                   wr_en;
    logic                   walk_last;
    logic [LETTER_W-1:0]    mod_val;

    assign lk         = letter_lookup(s_char_in);
    assign walk_last  = (walk_reg == LETTER_W'(NUM_LETTERS - 1));
    assign key_place  = cmd.do_key && !closed_reg && lk.hit && !used_reg[lk.idx];
    assign walk_place = cmd.walk_step && !used_reg[walk_reg];
    assign place      = key_place || walk_place;
    assign place_idx  = cmd.walk_step ? walk_reg : lk.idx;
    assign wr_en      = place && (fill_reg < LETTER_W'(NUM_LETTERS));

    // Table entries are written at the fill position and read by letter.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[fill_reg] <= place_idx;
        end
        if (cmd.enc_capture) begin
            rd_data_reg <= table_mem[lk.idx];
        end
    end

    always_comb begin
        used_next   = used_reg;
        fill_next   = fill_reg;
        closed_next = closed_reg;
        walk_next   = walk_reg;
        if (place) begin
            used_next[place_idx] = 1'b1;
        end
        if (wr_en) begin
            fill_next = fill_reg + LETTER_W'(1);
        end
        if (cmd.start_close) begin
            walk_next = '0;
        end else if (cmd.walk_step) begin
            walk_next = walk_reg + LETTER_W'(1);
            if (walk_last) begin
                closed_next = 1'b1;
            end
        end
        if (cmd.do_clear) begin
            used_next   = '0;
            fill_next   = '0;
            closed_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.enc_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            fill_reg    <= '0;
            closed_reg  <= 1'b0;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            fill_reg    <= fill_next;
            closed_reg  <= closed_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request fields are held while the table read completes.
    always_ff @(posedge aclk) begin
        if (cmd.enc_capture) begin
            char_reg      <= s_char_in;
            not_ready_reg <= !closed_reg;
            subst_reg     <= closed_reg && lk.hit;
        end
    end

    assign mod_val = (rd_data_reg >= LETTER_W'(NUM_LETTERS))
                   ? rd_data_reg - LETTER_W'(NUM_LETTERS) : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.enc_load) begin
            m_char_reg      <= subst_reg ? (UPPER_BASE + CHAR_W'(mod_val)) : char_reg;
            m_not_ready_reg <= not_ready_reg;
        end
    end

    assign stat.key_closed = closed_reg;
    assign stat.walk_last  = walk_last;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_char_out  = m_char_reg;
    assign m_not_ready = m_not_ready_reg;

endmodule

>>> bench/keyword_substitution_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher testbench
// A short table of directed requests covers the key, close, encrypt and clear
// corner cases. It is followed by random clear/key/close/encrypt sequences under
// three idle patterns and one long output stall. Each result is compared with
// a fixed value from the table or with a cycle-free model of the alphabet.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_tb;
    import kws_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam bit PREDICT      = 1'b0;
    localparam bit FIXED        = 1'b1;

    typedef struct {
        logic [7:0] char_out;
        logic       not_ready;
    } cipher_out_t;

    typedef struct {
        kws_op_t     op;
        logic [7:0]  ch;
        bit          fixed;
        cipher_out_t res;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_opcode;
    logic [7:0] s_char_in;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_out;
    logic       m_not_ready;

    // Model state of the substitution alphabet.
    logic [LETTER_W-1:0]    subst_tbl [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] used_mask;
    logic [4:0]             fill_cnt;
    logic                   key_done;

    cipher_out_t cipher_expect_q [$];
    dir_row_t    dir_rows [$];
    cipher_out_t no_fixed;

    int send_idle_pct;
    int recv_idle_pct;
    bit pressure_on;
    int items_sent;
    int fault_count;
    int cycle_count;

    keyword_substitution_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_char_in   (s_char_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_not_ready (m_not_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int letter_pos(input logic [7:0] c);
        int v;
        v = c;
        if (v >= UPPER_BASE && v < UPPER_BASE + NUM_LETTERS) begin
            return v - UPPER_BASE;
        end
        if (v >= LOWER_BASE && v < LOWER_BASE + NUM_LETTERS) begin
            return v - LOWER_BASE;
        end
        return -1;
    endfunction

    function automatic void place_letter(input int idx);
        if (fill_cnt < NUM_LETTERS) begin
            subst_tbl[fill_cnt] = LETTER_W'(idx);
            fill_cnt            = fill_cnt + 5'd1;
        end
        used_mask[idx] = 1'b1;
    endfunction

    function automatic void advance_cipher(input kws_op_t op, input logic [7:0] ch,
                                           output bit gives_out, output cipher_out_t res);
        int pos;
        pos           = letter_pos(ch);
        gives_out     = 1'b0;
        res.char_out  = ch;
        res.not_ready = 1'b0;
        case (op)
            OP_KEY: begin
                if (!key_done && pos >= 0 && !used_mask[pos]) place_letter(pos);
            end
            OP_CLOSE: begin
                if (!key_done) begin
                    for (int i = 0; i < NUM_LETTERS; i++) begin
                        if (!used_mask[i]) place_letter(i);
                    end
                    key_done = 1'b1;
                end
            end
            OP_ENCRYPT: begin
                gives_out = 1'b1;
                if (!key_done) begin
                    res.not_ready = 1'b1;
                end else if (pos >= 0) begin
                    res.char_out = UPPER_BASE + 8'(subst_tbl[pos] % NUM_LETTERS);
                end
            end
            default: begin
                used_mask = '0;
                fill_cnt  = '0;
                key_done  = 1'b0;
            end
        endcase
    endfunction

    function automatic void add_row(input kws_op_t op, input logic [7:0] ch, input bit fixed,
                                    input logic [7:0] exp_char, input logic exp_nr);
        dir_row_t r;
        r.op            = op;
        r.ch            = ch;
        r.fixed         = fixed;
        r.res.char_out  = exp_char;
        r.res.not_ready = exp_nr;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? UPPER_BASE : LOWER_BASE;
        return base + 8'($urandom_range(NUM_LETTERS - 1));
    endfunction

    function automatic logic [7:0] rand_text(input int letter_pct);
        if ($urandom_range(99) < letter_pct) return rand_letter();
        return 8'($urandom_range(255));
    endfunction

    // Offer one request, hold it until taken, then update the model.
    task automatic send_request(input kws_op_t op, input logic [7:0] ch,
                                input bit fixed, input cipher_out_t fixed_res);
        bit          gives_out;
        cipher_out_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_char_in <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_cipher(op, ch, gives_out, res);
        if (gives_out) cipher_expect_q.push_back(fixed ? fixed_res : res);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input kws_op_t op, input logic [7:0] ch);
        send_request(op, ch, PREDICT, no_fixed);
    endtask

    task automatic run_random(input int stop_at);
        int         len;
        int         j;
        int         tmp;
        int         order [NUM_LETTERS];
        logic [7:0] base;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 85) begin
                send_random(OP_CLEAR, 8'($urandom_range(255)));
                if ($urandom_range(7) == 0) begin
                    // The whole alphabet in shuffled order fills every slot from the key.
                    for (int i = 0; i < NUM_LETTERS; i++) order[i] = i;
                    for (int i = NUM_LETTERS - 1; i > 0; i--) begin
                        j        = $urandom_range(i);
                        tmp      = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                    for (int i = 0; i < NUM_LETTERS; i++) begin
                        base = $urandom_range(1) ? UPPER_BASE : LOWER_BASE;
                        send_random(OP_KEY, base + 8'(order[i]));
                    end
                    send_random(OP_KEY, rand_letter());
                    send_random(OP_KEY, rand_text(50));
                end else begin
                    len = $urandom_range(12, 1);
                    repeat (len) send_random(OP_KEY, rand_text(80));
                end
                if ($urandom_range(9) == 0) send_random(OP_ENCRYPT, rand_text(75));
                send_random(OP_CLOSE, 8'($urandom_range(255)));
                len = $urandom_range(40, 1);
                repeat (len) begin
                    case ($urandom_range(19))
                        0: send_random(OP_KEY, rand_letter());
                        1: send_random(OP_CLOSE, 8'($urandom_range(255)));
                        default: send_random(OP_ENCRYPT, rand_text(75));
                    endcase
                end
            end else begin
                len = $urandom_range(6, 1);
                repeat (len) send_random(kws_op_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Result side: random back-pressure plus one long stall once pressure is on.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left--;
            end else if (pressure_on && !hold_done) begin
                m_ready   <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cipher_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_expect_q.size() == 0) begin
                if (fault_count < MAX_REPORTS) begin
                    $display("unexpected result: char_out=%h not_ready=%b",
                             m_char_out, m_not_ready);
                end
                fault_count++;
            end else begin
                want = cipher_expect_q.pop_front();
                if (m_char_out !== want.char_out || m_not_ready !== want.not_ready) begin
                    if (fault_count < MAX_REPORTS) begin
                        $display("mismatch: char_out exp %h got %h, not_ready exp %b got %b",
                                 want.char_out, m_char_out, want.not_ready, m_not_ready);
                    end
                    fault_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyword_substitution_cipher verification failed");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_opcode      <= OP_KEY;
        s_char_in     <= 8'h00;
        send_idle_pct = 33;
        recv_idle_pct = 71;
        pressure_on   = 1'b0;
        items_sent    = 0;
        fault_count   = 0;
        cycle_count   = 0;
        no_fixed      = '{8'h00, 1'b0};
        for (int i = 0; i < NUM_LETTERS; i++) subst_tbl[i] = '0;
        used_mask = '0;
        fill_cnt  = '0;
        key_done  = 1'b0;

        // Before any close, text comes back untouched with the not-ready flag.
        add_row(OP_ENCRYPT, "A",   FIXED,   "A",   1'b1);
        add_row(OP_ENCRYPT, 8'h00, FIXED,   8'h00, 1'b1);
        add_row(OP_ENCRYPT, 8'hFF, FIXED,   8'hFF, 1'b1);
        // Key "ZEB" with a repeat in the other case, a digit and a high byte.
        add_row(OP_KEY,     "Z",   PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     "e",   PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     "E",   PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     "b",   PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     "7",   PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     8'hC1, PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     "z",   PREDICT, 8'h00, 1'b0);
        add_row(OP_CLOSE,   8'hFF, PREDICT, 8'h00, 1'b0);
        // A second close and a late key letter must both be ignored.
        add_row(OP_CLOSE,   8'h00, PREDICT, 8'h00, 1'b0);
        add_row(OP_KEY,     "Q",   PREDICT, 8'h00, 1'b0);
        add_row(OP_ENCRYPT, "a",   FIXED,   "Z",   1'b0);
        add_row(OP_ENCRYPT, "B",   FIXED,   "E",   1'b0);
        add_row(OP_ENCRYPT, "z",   PREDICT, 8'h00, 1'b0);
        add_row(OP_ENCRYPT, "q",   PREDICT, 8'h00, 1'b0);
        // Characters just outside both letter ranges, and a high byte, pass through.
        add_row(OP_ENCRYPT, "@",   FIXED,   "@",   1'b0);
        add_row(OP_ENCRYPT, "[",   FIXED,   "[",   1'b0);
        add_row(OP_ENCRYPT, 8'h60, FIXED,   8'h60, 1'b0);
        add_row(OP_ENCRYPT, "{",   FIXED,   "{",   1'b0);
        add_row(OP_ENCRYPT, 8'hFF, FIXED,   8'hFF, 1'b0);
        add_row(OP_CLEAR,   8'hFF, PREDICT, 8'h00, 1'b0);
        add_row(OP_ENCRYPT, "m",   FIXED,   "m",   1'b1);
        // Closing an empty key gives the identity alphabet.
        add_row(OP_CLOSE,   8'h00, PREDICT, 8'h00, 1'b0);
        add_row(OP_ENCRYPT, "q",   FIXED,   "Q",   1'b0);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].res);
        end

        run_random(640);
        send_idle_pct = 71;
        recv_idle_pct = 33;
        run_random(1260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_on   = 1'b1;
        run_random(1875);
        s_valid <= 1'b0;

        while (cipher_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0) begin
            $display("keyword_substitution_cipher verification clean");
        end else begin
            $display("keyword_substitution_cipher verification failed");
        end
        $finish;
    end

endmodule
